@@ hdl/bpc_pkg.sv @@
`default_nettype none

package bpc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned RAW_W    = 20;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned TEMP_W   = 16;
    localparam int unsigned PRES_W   = 28;
    localparam int unsigned IDX_W    = 4;
    localparam int unsigned CFG_W    = 64;

    localparam int unsigned MUL_A_W = 32;
    localparam int unsigned MUL_B_W = 64;
    localparam int unsigned MUL_P_W = 96;
    localparam int unsigned DIV_N_W = 128;
    localparam int unsigned DIV_D_W = 64;

    localparam logic [DIV_D_W-1:0] PF_CAP = 64'd1 << 38;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_DIV   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_PRES_BOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_TEMP_BOUND = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_STALE      = 3'd4;

    localparam logic [IDX_W-1:0] REG_TRIM_A      = 4'd0;
    localparam logic [IDX_W-1:0] REG_TRIM_B      = 4'd1;
    localparam logic [IDX_W-1:0] REG_TRIM_C      = 4'd2;
    localparam logic [IDX_W-1:0] REG_STALE_LIMIT = 4'd3;
    localparam logic [IDX_W-1:0] REG_PRES_MIN    = 4'd4;
    localparam logic [IDX_W-1:0] REG_PRES_MAX    = 4'd5;
    localparam logic [IDX_W-1:0] REG_TEMP_MIN    = 4'd6;
    localparam logic [IDX_W-1:0] REG_TEMP_MAX    = 4'd7;

    localparam logic [7:0]  RST_STALE_LIMIT = 8'd10;
    localparam logic [19:0] RST_PRES_MIN    = 20'd30000;
    localparam logic [19:0] RST_PRES_MAX    = 20'd110000;
    localparam logic [8:0]  RST_TEMP_MIN    = 9'd233;
    localparam logic [8:0]  RST_TEMP_MAX    = 9'd368;

    typedef struct packed {
        logic [CFG_W-1:0] trim_a;
        logic [CFG_W-1:0] trim_b;
        logic [CFG_W-1:0] trim_c;
        logic [7:0]       stale_limit;
        logic [19:0]      pressure_min;
        logic [19:0]      pressure_max;
        logic [8:0]       temp_min;
        logic [8:0]       temp_max;
    } cfg_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
        logic [CNT_W-1:0] repeat_count;
    } sample_t;

    typedef struct packed {
        logic                       start;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [MUL_P_W-1:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_D_W-1:0] q;
    } div_rsp_t;

    // round to nearest, ties toward plus infinity
    function automatic logic signed [MUL_P_W-1:0] rnd96(input logic signed [MUL_P_W-1:0] v,
                                                          input int unsigned s);
        logic signed [MUL_P_W-1:0] half;
        half = 96'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

endpackage

`default_nettype wire

@@ hdl/bpc_if.sv @@
`default_nettype none

interface bpc_sample_if;
    import bpc_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
    modport source(output valid, raw_pressure, raw_temperature, input ready);
    modport sink(input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bpc_result_if;
    import bpc_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TEMP_W-1:0]   temperature_out;
    logic [PRES_W-1:0]   pressure_out;
    modport source(output valid, status, temperature_out, pressure_out, input ready);
    modport sink(input valid, status, temperature_out, pressure_out, output ready);
endinterface

interface bpc_cfg_if;
    import bpc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/baro_pressure_temp_compensation.sv @@
// Barometric pressure and temperature compensation. Raw 20-bit pressure and
// temperature words enter on the sensor channel, pass a repeat detector and a
// short queue, and are compensated one at a time by a back end built around a
// bit-serial 32x64 multiplier (up to ten products a word) and a 128-step
// divider; the pressure pass is skipped when the divisor is zero. The queue
// lets the sensor side keep delivering while a word is in flight and a finished
// result waits on the result channel. Trimming words and limits must be written
// on the cfg channel only while the block is idle; the user is bound by this,
// the block itself does not enforce it. Indexes beyond the register list are
// ignored.
`default_nettype none

module baro_pressure_temp_compensation #(
    parameter int unsigned QueueDepth = bpc_pkg::QUEUE_DEPTH
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    bpc_cfg_if.sink       cfg,
    bpc_sample_if.sink    sensor,
    bpc_result_if.source  result
);
    import bpc_pkg::*;

    logic [CFG_W-1:0] trim_a_reg;
    logic [CFG_W-1:0] trim_b_reg;
    logic [CFG_W-1:0] trim_c_reg;
    logic [7:0]       stale_limit_reg;
    logic [19:0]      pres_min_reg;
    logic [19:0]      pres_max_reg;
    logic [8:0]       temp_min_reg;
    logic [8:0]       temp_max_reg;
    cfg_t             cfg_word;

    sample_t  push_data;
    logic     push_valid;
    logic     push_ready;
    sample_t  pop_data;
    logic     pop_valid;
    logic     pop_ready;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;
    div_req_t div_req;
    div_rsp_t div_rsp;

    assign cfg.ready = 1'b1;
    assign cfg_word  = '{trim_a: trim_a_reg, trim_b: trim_b_reg, trim_c: trim_c_reg,
                         stale_limit: stale_limit_reg,
                         pressure_min: pres_min_reg, pressure_max: pres_max_reg,
                         temp_min: temp_min_reg, temp_max: temp_max_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_a_reg      <= '0;
            trim_b_reg      <= '0;
            trim_c_reg      <= '0;
            stale_limit_reg <= RST_STALE_LIMIT;
            pres_min_reg    <= RST_PRES_MIN;
            pres_max_reg    <= RST_PRES_MAX;
            temp_min_reg    <= RST_TEMP_MIN;
            temp_max_reg    <= RST_TEMP_MAX;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TRIM_A:      trim_a_reg      <= cfg.data;
                REG_TRIM_B:      trim_b_reg      <= cfg.data;
                REG_TRIM_C:      trim_c_reg      <= cfg.data;
                REG_STALE_LIMIT: stale_limit_reg <= cfg.data[7:0];
                REG_PRES_MIN:    pres_min_reg    <= cfg.data[19:0];
                REG_PRES_MAX:    pres_max_reg    <= cfg.data[19:0];
                REG_TEMP_MIN:    temp_min_reg    <= cfg.data[8:0];
                REG_TEMP_MAX:    temp_max_reg    <= cfg.data[8:0];
                default:         ;
            endcase
        end
    end

    bpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .sensor     (sensor),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    bpc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    bpc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    bpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_word),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .mul_req   (mul_req),
        .mul_rsp   (mul_rsp),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ hdl/bpc_front.sv @@
`default_nettype none

module bpc_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bpc_sample_if.sink       sensor,
    output bpc_pkg::sample_t push_data,
    output logic             push_valid,
    input  wire logic        push_ready
);
    import bpc_pkg::*;

    logic [RAW_W-1:0] last_p_reg;
    logic [RAW_W-1:0] last_t_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             same;
    logic             accept;

    assign sensor.ready = push_ready;
    assign accept       = sensor.valid & push_ready;
    assign same         = (sensor.raw_pressure == last_p_reg) &&
                          (sensor.raw_temperature == last_t_reg);

    always_comb
    begin
        if (!same)
        begin
            count_next = '0;
        end
        else if (count_reg == {CNT_W{1'b1}})
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + 1'b1;
        end
    end

    assign push_valid = sensor.valid;
    assign push_data  = '{raw_pressure: sensor.raw_pressure,
                          raw_temperature: sensor.raw_temperature,
                          repeat_count: count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_p_reg <= '0;
            last_t_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            last_p_reg <= sensor.raw_pressure;
            last_t_reg <= sensor.raw_temperature;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bpc_queue.sv @@
`default_nettype none

module bpc_queue #(
    parameter int unsigned Depth = bpc_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    input  wire bpc_pkg::sample_t push_data,
    output logic                  push_ready,
    output logic                  pop_valid,
    output bpc_pkg::sample_t      pop_data,
    input  wire logic             pop_ready
);
    import bpc_pkg::*;

    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);

    sample_t             mem_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CntW-1:0]     count_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = count_reg != CntW'(Depth);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!do_push && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bpc_mul.sv @@
`default_nettype none

// shift-add signed multiplier, one bit of a per cycle
module bpc_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bpc_pkg::mul_req_t req,
    output bpc_pkg::mul_rsp_t      rsp
);
    import bpc_pkg::*;

    localparam int unsigned CntW = $clog2(MUL_A_W);
    localparam logic [CntW-1:0] LastCnt = CntW'(MUL_A_W - 1);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CntW-1:0]           cnt_reg;
    logic [MUL_A_W-1:0]        a_reg;
    logic signed [MUL_P_W-1:0] b_reg;
    logic signed [MUL_P_W-1:0] acc_reg;

    assign rsp = '{done: done_reg, p: acc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LastCnt)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg   <= req.a;
            b_reg   <= MUL_P_W'(req.b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            // top bit of a carries negative weight
            if (a_reg[0])
            begin
                acc_reg <= (cnt_reg == LastCnt) ? acc_reg - b_reg : acc_reg + b_reg;
            end
            b_reg <= b_reg <<< 1;
            a_reg <= a_reg >> 1;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bpc_div.sv @@
`default_nettype none

// restoring divider, 64-bit remainder, rounded and clamped quotient
module bpc_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bpc_pkg::div_req_t req,
    output bpc_pkg::div_rsp_t      rsp
);
    import bpc_pkg::*;

    localparam int unsigned CntW = $clog2(DIV_N_W);
    localparam logic [CntW-1:0] LastCnt = CntW'(DIV_N_W - 1);

    logic               busy_reg;
    logic               fin_reg;
    logic               done_reg;
    logic [CntW-1:0]    cnt_reg;
    logic [DIV_N_W-1:0] num_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W-1:0] r_reg;
    logic [DIV_D_W-1:0] q_reg;
    logic               sat_reg;

    logic [DIV_D_W-1:0] r_shift;
    logic [DIV_D_W-1:0] q_shift;
    logic               ge;
    logic [DIV_D_W-1:0] q_rnd;
    logic [DIV_D_W-1:0] q_fin;

    assign rsp     = '{done: done_reg, q: q_reg};
    assign r_shift = {r_reg[DIV_D_W-2:0], num_reg[DIV_N_W-1]};
    assign q_shift = {q_reg[DIV_D_W-2:0], 1'b0};
    assign ge      = r_shift >= den_reg;
    assign q_rnd   = q_reg + DIV_D_W'(!sat_reg && (r_reg >= den_reg - r_reg));
    assign q_fin   = (sat_reg || q_rnd > PF_CAP) ? PF_CAP : q_rnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg && fin_reg)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LastCnt)
                begin
                    fin_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            r_reg   <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg && fin_reg)
        begin
            q_reg <= q_fin;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << 1;
            sat_reg <= sat_reg | (q_reg[DIV_D_W-1:DIV_D_W-2] != 2'b00);
            r_reg   <= ge ? r_shift - den_reg : r_shift;
            q_reg   <= q_shift | DIV_D_W'(ge);
        end
    end

endmodule

`default_nettype wire

@@ hdl/bpc_back.sv @@
`default_nettype none

module bpc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bpc_pkg::cfg_t     cfg,
    input  wire logic              pop_valid,
    input  wire bpc_pkg::sample_t  pop_data,
    output logic                   pop_ready,
    output bpc_pkg::mul_req_t      mul_req,
    input  wire bpc_pkg::mul_rsp_t mul_rsp,
    output bpc_pkg::div_req_t      div_req,
    input  wire bpc_pkg::div_rsp_t div_rsp,
    bpc_result_if.source           result
);
    import bpc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TMUL1, ST_TMUL2, ST_X1A, ST_X1B, ST_YA, ST_YB,
        ST_DEN, ST_NUM, ST_DIV, ST_PA, ST_PB, ST_DONE
    } state_t;

    state_t                    state_reg;
    logic [RAW_W-1:0]          rp_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic signed [21:0]        ofs_reg;
    logic signed [30:0]        d_reg;
    logic signed [23:0]        temp_h_reg;
    logic signed [56:0]        x1_reg;
    logic                      n_neg_reg;
    logic                      y_neg_reg;
    logic [DIV_D_W-1:0]        mag_n_reg;
    logic [DIV_D_W-1:0]        den_reg;
    logic signed [27:0]        e_reg;
    logic                      mul_start_reg;
    logic signed [MUL_A_W-1:0] mul_a_reg;
    logic signed [MUL_B_W-1:0] mul_b_reg;
    logic                      div_start_reg;
    logic [DIV_N_W-1:0]        div_num_reg;
    logic [STATUS_W-1:0]       res_status_reg;
    logic [TEMP_W-1:0]         res_temp_reg;
    logic [PRES_W-1:0]         res_pres_reg;
    logic                      out_valid_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [TEMP_W-1:0]         out_temp_reg;
    logic [PRES_W-1:0]         out_pres_reg;

    logic [16:0]               t1;
    logic signed [15:0]        t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [15:0]               p1;
    logic signed [MUL_P_W-1:0] p;
    logic signed [21:0]        ofs_c;
    logic signed [MUL_P_W-1:0] sum_c;
    logic signed [MUL_P_W-1:0] tf16_c;
    logic signed [MUL_P_W-1:0] temp_c;
    logic signed [MUL_P_W-1:0] d_c;
    logic signed [MUL_P_W-1:0] x1_c;
    logic signed [MUL_P_W-1:0] y_c;
    logic signed [MUL_P_W-1:0] n_c;
    logic [DIV_D_W-1:0]        mag_y_c;
    logic [DIV_D_W-1:0]        mag_n_c;
    logic signed [MUL_P_W-1:0] pf_c;
    logic signed [MUL_P_W-1:0] e_c;
    logic signed [MUL_P_W-1:0] pq8_c;
    logic [16:0]               tmin100;
    logic [16:0]               tmax100;
    logic [TEMP_W-1:0]         temp_sat;
    logic [PRES_W-1:0]         pres_sat;
    logic [STATUS_W-1:0]       status_c;

    assign t1 = {1'b0, cfg.trim_a[15:0]};
    assign t2 = $signed(cfg.trim_a[31:16]);
    assign t3 = $signed(cfg.trim_a[47:32]);
    assign p1 = cfg.trim_a[63:48];
    assign p2 = $signed(cfg.trim_b[15:0]);
    assign p3 = $signed(cfg.trim_b[31:16]);
    assign p4 = $signed(cfg.trim_b[47:32]);
    assign p5 = $signed(cfg.trim_b[63:48]);
    assign p6 = $signed(cfg.trim_c[15:0]);
    assign p7 = $signed(cfg.trim_c[31:16]);
    assign p8 = $signed(cfg.trim_c[47:32]);
    assign p9 = $signed(cfg.trim_c[63:48]);

    assign p         = mul_rsp.p;
    assign pop_ready = state_reg == ST_IDLE;
    assign mul_req   = '{start: mul_start_reg, a: mul_a_reg, b: mul_b_reg};
    assign div_req   = '{start: div_start_reg, num: div_num_reg, den: den_reg};

    assign result.valid           = out_valid_reg;
    assign result.status          = out_status_reg;
    assign result.temperature_out = out_temp_reg;
    assign result.pressure_out    = out_pres_reg;

    always_comb
    begin
        ofs_c   = $signed({2'b00, pop_data.raw_temperature}) - $signed({1'b0, t1, 4'b0000});
        tf16_c  = rnd96(p, 18);
        temp_c  = rnd96((tf16_c <<< 2) + tf16_c, 24) + 96'sd27300;
        d_c     = rnd96(tf16_c, 12) - 96'sd2048000;
        x1_c    = rnd96(p, 23) + (MUL_P_W'(p4) <<< 20) - (96'sd1 <<< 36);
        y_c     = rnd96(p, 23) + (96'sd1 <<< 40);
        n_c     = $signed(MUL_P_W'({rp_reg, 16'h0000})) + MUL_P_W'(x1_reg);
        mag_y_c = y_c[MUL_P_W-1] ? DIV_D_W'(-y_c) : DIV_D_W'(y_c);
        mag_n_c = n_c[MUL_P_W-1] ? DIV_D_W'(-n_c) : DIV_D_W'(n_c);
        pf_c    = (n_neg_reg == y_neg_reg) ? -$signed(MUL_P_W'(div_rsp.q))
                                           : $signed(MUL_P_W'(div_rsp.q));
        e_c     = rnd96(pf_c, 12);
        pq8_c   = rnd96(p, 35) + (MUL_P_W'(p7) <<< 4);
        tmin100 = 17'(cfg.temp_min) * 17'd100;
        tmax100 = 17'(cfg.temp_max) * 17'd100;

        unique case (state_reg)
            ST_TMUL1: sum_c = p + (MUL_P_W'(t2) <<< 20);
            ST_X1A:   sum_c = p + (MUL_P_W'(p5) <<< 21);
            ST_YA:    sum_c = p + (MUL_P_W'(p2) <<< 24);
            ST_PA:    sum_c = p + (MUL_P_W'(p8) <<< 20) + (96'sd1 <<< 39);
            default:  sum_c = p;
        endcase

        if (temp_c < 0)
        begin
            temp_sat = '0;
        end
        else if (temp_c > 96'sd65535)
        begin
            temp_sat = '1;
        end
        else
        begin
            temp_sat = temp_c[TEMP_W-1:0];
        end

        if (pq8_c < 0)
        begin
            pres_sat = '0;
        end
        else if (pq8_c > 96'sd268435455)
        begin
            pres_sat = '1;
        end
        else
        begin
            pres_sat = pq8_c[PRES_W-1:0];
        end

        if (pq8_c < $signed(MUL_P_W'({cfg.pressure_min, 8'h00})) ||
            pq8_c > $signed(MUL_P_W'({cfg.pressure_max, 8'h00})))
        begin
            status_c = STATUS_PRES_BOUND;
        end
        else if (temp_h_reg < $signed({1'b0, tmin100}) ||
                 temp_h_reg > $signed({1'b0, tmax100}))
        begin
            status_c = STATUS_TEMP_BOUND;
        end
        else if (cnt_reg >= cfg.stale_limit)
        begin
            status_c = STATUS_STALE;
        end
        else
        begin
            status_c = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            rp_reg         <= '0;
            cnt_reg        <= '0;
            ofs_reg        <= '0;
            d_reg          <= '0;
            temp_h_reg     <= '0;
            x1_reg         <= '0;
            n_neg_reg      <= 1'b0;
            y_neg_reg      <= 1'b0;
            mag_n_reg      <= '0;
            den_reg        <= '0;
            e_reg          <= '0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
            div_num_reg    <= '0;
            res_status_reg <= STATUS_OK;
            res_temp_reg   <= '0;
            res_pres_reg   <= '0;
            out_status_reg <= STATUS_OK;
            out_temp_reg   <= '0;
            out_pres_reg   <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        rp_reg        <= pop_data.raw_pressure;
                        cnt_reg       <= pop_data.repeat_count;
                        ofs_reg       <= ofs_c;
                        mul_a_reg     <= MUL_A_W'(ofs_c);
                        mul_b_reg     <= MUL_B_W'(t3);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_TMUL1;
                    end
                end
                ST_TMUL1:
                begin
                    if (mul_rsp.done)
                    begin
                        mul_a_reg     <= MUL_A_W'(ofs_reg);
                        mul_b_reg     <= MUL_B_W'(sum_c);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_TMUL2;
                    end
                end
                ST_TMUL2:
                begin
                    if (mul_rsp.done)
                    begin
                        temp_h_reg    <= 24'(temp_c);
                        res_temp_reg  <= temp_sat;
                        d_reg         <= 31'(d_c);
                        mul_a_reg     <= MUL_A_W'(d_c);
                        mul_b_reg     <= MUL_B_W'(p6);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_X1A;
                    end
                end
                ST_X1A:
                begin
                    if (mul_rsp.done)
                    begin
                        mul_a_reg     <= MUL_A_W'(d_reg);
                        mul_b_reg     <= MUL_B_W'(sum_c);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_X1B;
                    end
                end
                ST_X1B:
                begin
                    if (mul_rsp.done)
                    begin
                        x1_reg        <= 57'(x1_c);
                        mul_a_reg     <= MUL_A_W'(d_reg);
                        mul_b_reg     <= MUL_B_W'(p3);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_YA;
                    end
                end
                ST_YA:
                begin
                    if (mul_rsp.done)
                    begin
                        mul_a_reg     <= MUL_A_W'(d_reg);
                        mul_b_reg     <= MUL_B_W'(sum_c);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_YB;
                    end
                end
                ST_YB:
                begin
                    if (mul_rsp.done)
                    begin
                        if (p1 == '0 || y_c == '0)
                        begin
                            res_status_reg <= STATUS_ZERO_DIV;
                            res_pres_reg   <= '0;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            y_neg_reg     <= y_c[MUL_P_W-1];
                            n_neg_reg     <= n_c[MUL_P_W-1];
                            mag_n_reg     <= mag_n_c;
                            mul_a_reg     <= $signed(MUL_A_W'(p1));
                            mul_b_reg     <= $signed(mag_y_c);
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_DEN;
                        end
                    end
                end
                ST_DEN:
                begin
                    if (mul_rsp.done)
                    begin
                        den_reg       <= p[DIV_D_W-1:0];
                        mul_a_reg     <= 32'sd100000;
                        mul_b_reg     <= $signed(mag_n_reg);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_NUM;
                    end
                end
                ST_NUM:
                begin
                    if (mul_rsp.done)
                    begin
                        div_num_reg   <= {p[DIV_N_W-37:0], 36'h0};
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        e_reg         <= 28'(e_c);
                        mul_a_reg     <= MUL_A_W'(e_c);
                        mul_b_reg     <= MUL_B_W'(p9);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_PA;
                    end
                end
                ST_PA:
                begin
                    if (mul_rsp.done)
                    begin
                        mul_a_reg     <= MUL_A_W'(e_reg);
                        mul_b_reg     <= MUL_B_W'(sum_c);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_PB;
                    end
                end
                ST_PB:
                begin
                    if (mul_rsp.done)
                    begin
                        res_status_reg <= status_c;
                        res_pres_reg   <= pres_sat;
                        state_reg      <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_temp_reg   <= res_temp_reg;
                        out_pres_reg   <= res_pres_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_mul_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_TMUL1 || state_reg == ST_TMUL2 ||
                          state_reg == ST_X1A || state_reg == ST_X1B ||
                          state_reg == ST_YA || state_reg == ST_YB ||
                          state_reg == ST_DEN || state_reg == ST_NUM ||
                          state_reg == ST_PA || state_reg == ST_PB))
        else $error("multiplier finished outside a wait state");
    a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");
    a_zero_div_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status == STATUS_ZERO_DIV) |-> result.pressure_out == '0)
        else $error("zero divisor word carries nonzero pressure");
    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> (state_reg == ST_TMUL1 && $past(mul_start_reg) == 1'b0))
        else $error("popped word did not start the temperature pass");
`endif

endmodule

`default_nettype wire

@@ verif/bpc_comp_checker.sv @@
`timescale 1ns / 100ps

module bpc_comp_checker
    import bpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bpc_cfg_if        cfg,
    bpc_sample_if     sensor,
    bpc_result_if     result,
    output int        errors,
    output int        pending
);

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TEMP_W-1:0]   temperature;
        logic [PRES_W-1:0]   pressure;
    } reading_t;

    logic [CFG_W-1:0] trim_a, trim_b, trim_c;
    logic [7:0]       stale_lim;
    logic [19:0]      pres_min, pres_max;
    logic [8:0]       temp_min, temp_max;
    logic [RAW_W-1:0] prev_p, prev_t;
    logic [CNT_W-1:0] repeats;
    reading_t         readings_due[$];

    function automatic wide_t round_sh(wide_t v, int s);
        return (v + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic wide_t trim_s16(logic [63:0] w, int pos);
        logic signed [15:0] h;
        h = w[pos +: 16];
        return wide_t'(h);
    endfunction

    function automatic reading_t compensate(logic [RAW_W-1:0] rp, logic [RAW_W-1:0] rt);
        wide_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        wide_t ofs, tf16, temp_h, d, x1, y, n, pf, e, pq8;
        logic [127:0] mag_n, mag_y, num, den, prod, quo, rem, q;
        logic neg;
        reading_t r;
        t1 = wide_t'({112'd0, trim_a[15:0]});
        t2 = trim_s16(trim_a, 16);
        t3 = trim_s16(trim_a, 32);
        p1 = wide_t'({112'd0, trim_a[63:48]});
        p2 = trim_s16(trim_b, 0);
        p3 = trim_s16(trim_b, 16);
        p4 = trim_s16(trim_b, 32);
        p5 = trim_s16(trim_b, 48);
        p6 = trim_s16(trim_c, 0);
        p7 = trim_s16(trim_c, 16);
        p8 = trim_s16(trim_c, 32);
        p9 = trim_s16(trim_c, 48);

        ofs    = wide_t'({108'd0, rt}) - 16 * t1;
        tf16   = round_sh(ofs * (ofs * t3 + (t2 <<< 20)), 18);
        temp_h = round_sh(5 * tf16, 24) + 27300;
        r.temperature = temp_h < 0 ? '0 : (temp_h > 65535 ? '1 : temp_h[15:0]);

        d  = round_sh(tf16, 12) - 2048000;
        x1 = round_sh(d * (d * p6 + (p5 <<< 21)), 23) + (p4 <<< 20) - (wide_t'(1) <<< 36);
        y  = round_sh(d * (d * p3 + (p2 <<< 24)), 23) + (wide_t'(16) <<< 36);

        r.status   = STATUS_OK;
        r.pressure = '0;
        if (p1 == 0 || y == 0)
        begin
            r.status = STATUS_ZERO_DIV;
        end
        else
        begin
            n     = wide_t'({108'd0, rp}) * 65536 + x1;
            mag_n = n < 0 ? -n : n;
            mag_y = y < 0 ? -y : y;
            neg   = (n < 0) == (y < 0);
            num   = (mag_n * 128'd100000) << 36;
            prod  = p1 * mag_y;
            den   = {64'd0, prod[63:0]};
            quo   = num / den;
            rem   = num % den;
            if (quo >= (128'd1 << 63))
                q = {64'd0, PF_CAP};
            else
                q = quo + ((rem >= den - rem) ? 128'd1 : 128'd0);
            if (q > {64'd0, PF_CAP})
                q = {64'd0, PF_CAP};
            pf  = neg ? -wide_t'(q) : wide_t'(q);
            e   = round_sh(pf, 12);
            pq8 = round_sh(e * (e * p9 + (p8 <<< 20) + (wide_t'(1) <<< 39)), 35) + 16 * p7;
            r.pressure = pq8 < 0 ? '0 :
                         (pq8 > wide_t'(28'hFFFFFFF) ? '1 : pq8[PRES_W-1:0]);
            if (pq8 < wide_t'(pres_min) * 256 || pq8 > wide_t'(pres_max) * 256)
                r.status = STATUS_PRES_BOUND;
            else if (temp_h < wide_t'(temp_min) * 100 || temp_h > wide_t'(temp_max) * 100)
                r.status = STATUS_TEMP_BOUND;
            else if (repeats >= stale_lim)
                r.status = STATUS_STALE;
        end
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            trim_a    = '0;
            trim_b    = '0;
            trim_c    = '0;
            stale_lim = RST_STALE_LIMIT;
            pres_min  = RST_PRES_MIN;
            pres_max  = RST_PRES_MAX;
            temp_min  = RST_TEMP_MIN;
            temp_max  = RST_TEMP_MAX;
            prev_p    = '0;
            prev_t    = '0;
            repeats   = '0;
            readings_due.delete();
            errors    = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (readings_due.size() == 0)
                begin
                    report("unexpected word", 64'(result.status), 64'd0);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (result.status !== want.status)
                        report("status", 64'(result.status), 64'(want.status));
                    if (result.temperature_out !== want.temperature)
                        report("temperature", 64'(result.temperature_out),
                               64'(want.temperature));
                    if (result.pressure_out !== want.pressure)
                        report("pressure", 64'(result.pressure_out), 64'(want.pressure));
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_TRIM_A:      trim_a    = cfg.data;
                    REG_TRIM_B:      trim_b    = cfg.data;
                    REG_TRIM_C:      trim_c    = cfg.data;
                    REG_STALE_LIMIT: stale_lim = cfg.data[7:0];
                    REG_PRES_MIN:    pres_min  = cfg.data[19:0];
                    REG_PRES_MAX:    pres_max  = cfg.data[19:0];
                    REG_TEMP_MIN:    temp_min  = cfg.data[8:0];
                    REG_TEMP_MAX:    temp_max  = cfg.data[8:0];
                    default: ;
                endcase
            end
            if (sensor.valid && sensor.ready)
            begin
                if (sensor.raw_pressure == prev_p && sensor.raw_temperature == prev_t)
                begin
                    if (repeats != 8'hFF)
                        repeats = repeats + 1'b1;
                end
                else
                begin
                    repeats = '0;
                end
                prev_p = sensor.raw_pressure;
                prev_t = sensor.raw_temperature;
                readings_due.push_back(compensate(sensor.raw_pressure, sensor.raw_temperature));
            end
        end
        pending = readings_due.size();
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import bpc_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int N_PHASES   = 8;
    localparam int PHASE_ITEMS = 166;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 4'd9;
    localparam logic [IDX_W-1:0] REG_TOP      = 4'd15;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   send_idle;
    int   recv_idle;
    int   sent;
    int   quiet_cycles;
    logic [RAW_W-1:0] last_p, last_t;

    bpc_cfg_if    cfg_ch();
    bpc_sample_if smp_ch();
    bpc_result_if res_ch();

    baro_pressure_temp_compensation dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sensor (smp_ch),
        .result (res_ch)
    );

    bpc_comp_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .sensor  (smp_ch),
        .result  (res_ch),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(negedge clk)
    begin
        res_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_sample(logic [RAW_W-1:0] rp, logic [RAW_W-1:0] rt);
        send_idle = sent < 450 ? 38 : (sent < 900 ? 88 : 0);
        recv_idle = sent < 450 ? 88 : (sent < 900 ? 38 : 0);
        while ($urandom_range(99) < send_idle)
        begin
            smp_ch.valid <= 1'b0;
            @(negedge clk);
        end
        smp_ch.valid           <= 1'b1;
        smp_ch.raw_pressure    <= rp;
        smp_ch.raw_temperature <= rt;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
        @(negedge clk);
        last_p = rp;
        last_t = rt;
        sent++;
    endtask

    // drop the sample valid and wait for every outstanding word to drain
    task automatic settle;
        smp_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_limits(logic [7:0] stale, logic [19:0] pmin, logic [19:0] pmax,
                              logic [8:0] tmin, logic [8:0] tmax);
        write_reg(REG_STALE_LIMIT, 64'(stale));
        write_reg(REG_PRES_MIN, 64'(pmin));
        write_reg(REG_PRES_MAX, 64'(pmax));
        write_reg(REG_TEMP_MIN, 64'(tmin));
        write_reg(REG_TEMP_MAX, 64'(tmax));
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial
    begin
        logic [63:0] ta;
        int mode;
        int pick;
        rst_n           = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        smp_ch.valid    = 1'b0;
        smp_ch.raw_pressure    = '0;
        smp_ch.raw_temperature = '0;
        res_ch.ready    = 1'b0;
        send_idle       = 38;
        recv_idle       = 88;
        sent            = 0;
        quiet_cycles    = 0;
        last_p          = '0;
        last_t          = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings, zero trims: zero divisor everywhere
        send_sample('0, '0);
        send_sample('0, '0);
        send_sample('1, '1);
        send_sample('1, '1);

        // divisor of 2^40, saturating quotient both signs
        settle();
        write_reg(REG_TRIM_A, 64'h0001_0000_0000_0000);
        write_reg(REG_TRIM_B, 64'h0000_7FFF_0000_0000);
        write_reg(REG_TRIM_C, 64'h0000_0000_0000_0000);
        set_limits(8'd1, 20'd0, 20'hFFFFF, 9'd0, 9'h1FF);
        cfg_ch.valid <= 1'b0;
        repeat (3)
        begin
            send_sample('1, 20'd0);
            send_sample('1, 20'd0);
            send_sample('0, '1);
        end

        // y cancels to zero
        settle();
        write_reg(REG_TRIM_A, 64'h03E8_0000_5FC0_0000);
        write_reg(REG_TRIM_B, 64'h0000_0000_0000_8000);
        write_reg(REG_UNMAPPED, rand64());
        write_reg(REG_TOP, rand64());
        write_reg(REG_STALE_LIMIT, 64'd0);
        cfg_ch.valid <= 1'b0;
        send_sample(20'h12345, 20'd786432);
        send_sample(20'h12345, 20'd786432);
        send_sample(20'h12345, 20'd786433);

        settle();
        write_reg(REG_STALE_LIMIT, 64'd255);
        cfg_ch.valid <= 1'b0;
        send_sample(20'h54321, 20'd786432);
        send_sample(20'h54321, 20'd786432);
        send_sample('1, 20'd786431);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            settle();
            ta = rand64();
            if (ph % 2 == 0)
                ta[47:32] = 16'($signed($urandom_range(6)) - 3);
            if (ph == 1)
                ta[63:48] = 16'd0;
            write_reg(REG_TRIM_A, ta);
            write_reg(REG_TRIM_B, rand64());
            write_reg(REG_TRIM_C, rand64());
            mode = ph % 4;
            case (mode)
                0: set_limits(8'(1 + $urandom_range(3)), 20'd0, 20'hFFFFF, 9'd0, 9'h1FF);
                1: set_limits(RST_STALE_LIMIT, RST_PRES_MIN, RST_PRES_MAX,
                              RST_TEMP_MIN, RST_TEMP_MAX);
                2: set_limits(8'($urandom), 20'($urandom), 20'($urandom),
                              9'($urandom), 9'($urandom));
                default: set_limits(8'd0, 20'hFFFFF, 20'd0, 9'h1FF, 9'd0);
            endcase
            cfg_ch.valid <= 1'b0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                    send_sample(last_p, last_t);
                else if (pick < 45)
                    send_sample($urandom_range(1) ? '1 : '0, $urandom_range(1) ? '1 : '0);
                else if (pick < 65)
                    send_sample(20'($urandom),
                                20'({ta[15:0], 4'd0} + 20'($urandom_range(4095)) - 20'd2048));
                else
                    send_sample(20'($urandom), 20'($urandom));
            end
        end

        settle();
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
